// ===== rtl/core/fdmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame difference motion detector package
// Widths, verdict and command codes, and the types shared by the detector's
// modules.
// ----------------------------------------------------------------------------
package fdmd_pkg;

    localparam int PIX_W = 8;       // grayscale pixel
    localparam int SUM_W = 24;      // difference accumulator and result sum
    localparam int LEN_W = 17;      // frame length register
    localparam int THR_W = 25;      // 255 * length
    localparam int PROD_W = 32;     // 200 * sum
    localparam int VERDICT_W = 2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_FIRST  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MOTION = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_QUIET  = 2'd2;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Control that travels with one item from the address stage to the
    // accumulate stage.
    typedef struct packed {
        logic clr;
        logic last;
    } t_item_ctl;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [SUM_W-1:0]     sum;
    } t_result;

endpackage

// ===== rtl/core/fdmd_store.sv =====
// ----------------------------------------------------------------------------
// Frame store
// Single-port-read, single-port-write pixel memory with a registered read
// and forwarding of a write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module fdmd_store import fdmd_pkg::*; #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]  i_wr_data,
    output logic [PIX_W-1:0]  o_rd_data
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [PIX_W-1:0] r_fwd_data;
    logic             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // The array returns the old contents on a same-address collision, so the
    // newer pixel is kept aside and substituted.
    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_wr_data;
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr) |=> o_rd_data == $past(i_wr_data))
        else $error("frame store read missed a same-cycle write");

endmodule

// ===== rtl/core/fdmd_accum.sv =====
// ----------------------------------------------------------------------------
// Difference accumulator
// Sums absolute pixel differences over a frame and, on the last pixel, forms
// the result and its motion verdict in a second stage.
// ----------------------------------------------------------------------------
module fdmd_accum import fdmd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item_ctl        i_ctl,
    input  logic [PIX_W-1:0] i_pix,
    input  logic [PIX_W-1:0] i_old,
    input  logic [THR_W-1:0] i_thresh,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [SUM_W-1:0]  r_acc;
    logic              r_have_prev;
    logic              r_s2_valid;
    logic              r_s2_first;
    logic [SUM_W-1:0]  r_s2_sum;

    logic [PIX_W-1:0]  diff;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  acc_sat;
    logic [SUM_W-1:0]  n_acc;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum_ext;

    assign diff     = (i_pix >= i_old) ? (i_pix - i_old) : (i_old - i_pix);
    assign sum_wide = {1'b0, r_acc} + (SUM_W + 1)'(diff);
    assign acc_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign n_acc    = r_have_prev ? acc_sat : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_have_prev <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            r_s2_valid <= 1'b0;
            if (i_valid) begin
                if (i_ctl.clr) begin
                    r_acc       <= '0;
                    r_have_prev <= 1'b0;
                end else if (i_ctl.last) begin
                    r_acc       <= '0;
                    r_have_prev <= 1'b1;
                    r_s2_valid  <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !i_ctl.clr && i_ctl.last) begin
            r_s2_first <= !r_have_prev;
            r_s2_sum   <= r_have_prev ? n_acc : '0;
        end
    end

    // 200 * sum as three shifted copies.
    assign sum_ext = PROD_W'(r_s2_sum);
    assign prod    = (sum_ext << 7) + (sum_ext << 6) + (sum_ext << 3);

    assign o_res_valid = r_s2_valid;
    always_comb begin
        o_res.sum = r_s2_sum;
        if (r_s2_first) begin
            o_res.verdict = VERDICT_FIRST;
        end else if (prod > PROD_W'(i_thresh)) begin
            o_res.verdict = VERDICT_MOTION;
        end else begin
            o_res.verdict = VERDICT_QUIET;
        end
    end

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(i_valid && !i_ctl.clr && i_ctl.last))
        else $error("result raised without a last pixel");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_first |-> r_s2_sum == '0)
        else $error("stored-only frame carries a nonzero sum");

endmodule

// ===== rtl/core/fdmd_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small register FIFO that decouples the result stream from the pixel stream.
// ----------------------------------------------------------------------------
module fdmd_outq import fdmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_push_data,
    input  logic               i_pop_ready,
    output logic               o_valid,
    output t_result            o_data,
    output logic [Q_CNT_W-1:0] o_count
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < Q_CNT_W'(Q_DEPTH)) || pop)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count out of range");

endmodule

// ===== rtl/core/frame_difference_motion_detector.sv =====
// ----------------------------------------------------------------------------
// Frame difference motion detector
// Compares each incoming grayscale frame against the previous one held in an
// on-chip frame store and reports a motion verdict once per frame.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock cycle while input ready is
// high, and keeps taking pixels while a result waits on the output; the rate
// is set by the frame store, which does one read and one write per pixel. A
// pixel's stored predecessor is read at the edge that accepts the pixel, and
// the new pixel is written back in the following cycle; a write that collides
// with the read of the next pixel is forwarded. A frame's result is registered
// in the accumulator and reaches the output through a four-entry result queue.
// Input ready falls only when the queue and the items still in the pipeline
// could fill it, that is when the result side has stalled. The
// verdict is motion when 200 * sum > 255 * length, otherwise no motion; the
// first frame after reset or after a clear transaction is only stored and
// reports verdict zero and a zero sum. A clear transaction produces no
// result. The frame store has no reset and no clearing pass: its contents
// only count once a full frame has been written. A frame length of zero acts
// as one and a length above FRAME_PIXELS acts as FRAME_PIXELS; the
// configuration write is accepted in every cycle and is meant to happen only
// while no pixel is in flight.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector import fdmd_pkg::*; #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: frame length in pixels.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LEN_W-1:0]     i_cfg_data,
    // Pixel stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,     // [7:0] pixel
    input  logic                 s_axis_tuser,     // [0] cmd
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SUM_W-1:0]     m_axis_tdata,     // [23:0] difference_sum
    output logic [VERDICT_W-1:0] m_axis_tuser      // [1:0] verdict
);

    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((FRAME_PIXELS > LEN_MAX) ? LEN_MAX : FRAME_PIXELS);
    localparam int RST_LEN = (FRAME_PIXELS < 65536) ? FRAME_PIXELS : 65536;
    localparam logic [ADDR_W-1:0] RST_LAST = ADDR_W'(RST_LEN - 1);
    localparam logic [THR_W-1:0]  RST_THR  = THR_W'(255 * RST_LEN);

    // Configuration: the effective length is resolved at write time into
    // the last pixel position and the verdict threshold 255 * length.
    logic [ADDR_W-1:0] r_last_pos;
    logic [THR_W-1:0]  r_thresh;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  eff_m1;
    logic              cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_cfg_data > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = i_cfg_data;
        end
    end
    assign eff_m1 = eff_len - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= RST_LAST;
            r_thresh   <= RST_THR;
        end else if (cfg_write) begin
            r_last_pos <= ADDR_W'(eff_m1);
            r_thresh   <= (THR_W'(eff_len) << 8) - THR_W'(eff_len);
        end
    end

    // Address stage: the pixel position counter picks the store entry.
    logic                in_accept;
    logic                is_pixel;
    logic                is_last;
    logic [ADDR_W-1:0]   r_pos;
    logic [ADDR_W-1:0]   n_pos;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_pixel  = (s_axis_tuser == CMD_PIXEL);
    // A length lowered mid-frame ends the frame on the next pixel.
    assign is_last   = (r_pos >= r_last_pos);

    always_comb begin
        n_pos = r_pos;
        if (in_accept) begin
            if (!is_pixel || is_last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Accumulate stage registers: the item whose store read is returning.
    logic              r_s1_valid;
    t_item_ctl         r_s1_ctl;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl.clr  <= !is_pixel;
            r_s1_ctl.last <= is_last;
            r_s1_addr     <= r_pos;
            r_s1_pix      <= s_axis_tdata;
        end
    end

    logic [PIX_W-1:0] old_pix;
    logic             store_wr;

    assign store_wr = r_s1_valid && !r_s1_ctl.clr;

    fdmd_store #(
        .DEPTH  (FRAME_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && is_pixel),
        .i_rd_addr (r_pos),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_pix),
        .o_rd_data (old_pix)
    );

    logic    res_valid;
    t_result res;

    fdmd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_ctl       (r_s1_ctl),
        .i_pix       (r_s1_pix),
        .i_old       (old_pix),
        .i_thresh    (r_thresh),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    logic [Q_CNT_W-1:0] q_count;
    t_result            q_data;
    logic [Q_CNT_W:0]   in_flight;

    fdmd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    // Every item still in the pipeline may turn into one result, so it
    // reserves a queue entry.
    assign in_flight = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(r_s1_valid)
                     + (Q_CNT_W + 1)'(res_valid);
    assign s_axis_tready = (in_flight < (Q_CNT_W + 1)'(Q_DEPTH));

    assign m_axis_tdata = q_data.sum;
    assign m_axis_tuser = q_data.verdict;

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !is_pixel |=> r_pos == '0)
        else $error("clear did not restart the frame position");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_ctl.clr && r_s1_ctl.last |-> r_pos == '0)
        else $error("frame position did not wrap after the last pixel");

endmodule
